FILE: src/rcmm_pkg.sv
// ----------------------------------------------------------------------------
// rcmm_pkg
// Types and constants shared by the RCMM infrared frame encoder.
// ----------------------------------------------------------------------------
package rcmm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS    = 2'd2;

    localparam logic [5:0] FRAME_BITS_RST  = 6'd32;
    localparam logic       TRAILER_EN_RST  = 1'b1;
    localparam logic [9:0] PAUSE_TICKS_RST = 10'd110;

    localparam logic [4:0] DUR_HDR_ON   = 5'd15;
    localparam logic [4:0] DUR_HDR_OFF  = 5'd10;
    localparam logic [4:0] DUR_PULSE    = 5'd6;
    localparam logic [4:0] DUR_NO_TRAIL = 5'd1;
    localparam logic [4:0] DUR_NONE     = 5'd0;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_HDR_A = 7'b0000010,
        PH_HDR_B = 7'b0000100,
        PH_BIT_A = 7'b0001000,
        PH_BIT_B = 7'b0010000,
        PH_TRAIL = 7'b0100000,
        PH_WAIT  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [5:0] frame_bits;
        logic       trailer_enable;
        logic [9:0] pause_ticks;
    } cfg_t;

    typedef struct packed {
        logic       carrier_on;
        logic [4:0] duration;
        logic       busy_res;
        logic       accepted;
    } result_t;

    function automatic logic [4:0] pair_off_time(input logic [1:0] pair);
        logic [4:0] t;
        case (pair)
            2'b00:   t = 5'd10;
            2'b01:   t = 5'd16;
            2'b10:   t = 5'd22;
            2'b11:   t = 5'd28;
            default: t = 5'd10;
        endcase
        return t;
    endfunction

endpackage

FILE: src/rcmm_if.sv
// ----------------------------------------------------------------------------
// rcmm_in_if / rcmm_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface rcmm_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] code_word;

    modport source (output valid, output req_type, output code_word, input ready);
    modport sink (input valid, input req_type, input code_word, output ready);
endinterface

interface rcmm_out_if;
    logic       valid;
    logic       ready;
    logic       carrier_on;
    logic [4:0] duration;
    logic       busy_res;
    logic       accepted;

    modport source (output valid, output carrier_on, output duration, output busy_res,
                    output accepted, input ready);
    modport sink (input valid, input carrier_on, input duration, input busy_res,
                  input accepted, output ready);
endinterface

FILE: src/rcmm_ir_frame_encoder.sv
// ----------------------------------------------------------------------------
// rcmm_ir_frame_encoder
// RCMM infrared frame encoder with a registered result channel.
//
// A beat on req either starts a frame (req_type = 1, nonzero code_word, block
// idle) or is a timer tick (req_type = 0) that asks for the next carrier
// interval. Every request beat yields exactly one result beat on res with the
// carrier state, the interval length in timer units, a busy flag and whether
// a start was taken. The sequencer updates in the cycle the request beat is
// accepted; the result appears in the output register on the next cycle, and
// one beat per cycle is sustained while res.ready is high. req.ready is high
// whenever the output register is empty or being drained in the same cycle,
// so a stalled receiver holds the result and back-pressures requests after
// one beat. The cfg port writes frame_bits, trailer_enable and pause_ticks
// by index; writes take effect on the next cycle. Reset returns the block to
// idle with registers at 32, 1 and 110 and no result pending.
// ----------------------------------------------------------------------------
module rcmm_ir_frame_encoder
(
    input  logic                             clk,
    input  logic                             rst_n,
    rcmm_in_if.sink                          req,
    rcmm_out_if.source                       res,
    input  logic                             cfg_we,
    input  logic [rcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rcmm_pkg::cfg_t    cfg;
    rcmm_pkg::result_t step_result;
    rcmm_pkg::result_t res_data_reg;
    logic              res_valid_reg, res_valid_next;
    logic              req_fire;

    assign req.ready = !res_valid_reg || res.ready;
    assign req_fire  = req.valid && req.ready;

    rcmm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcmm_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (req_fire),
        .req_type   (req.req_type),
        .code_word  (req.code_word),
        .cfg        (cfg),
        .result     (step_result)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (req_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_data_reg <= step_result;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.carrier_on = res_data_reg.carrier_on;
    assign res.duration   = res_data_reg.duration;
    assign res.busy_res   = res_data_reg.busy_res;
    assign res.accepted   = res_data_reg.accepted;

    a_beat_in_beat_out : assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> res_valid_reg)
        else $error("request beat produced no result");

    a_no_accept_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !req_fire)
        else $error("request taken while result is stalled");

    a_stall_holds_result : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> res_valid_reg && $stable(res_data_reg))
        else $error("stalled result changed");

endmodule

FILE: src/rcmm_cfg.sv
// ----------------------------------------------------------------------------
// rcmm_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module rcmm_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcmm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rcmm_pkg::cfg_t                   cfg
);

    rcmm_pkg::cfg_t cfg_reg;
    rcmm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rcmm_pkg::REG_FRAME_BITS:     cfg_next.frame_bits     = cfg_data[5:0];
                rcmm_pkg::REG_TRAILER_ENABLE: cfg_next.trailer_enable = cfg_data[0];
                rcmm_pkg::REG_PAUSE_TICKS:    cfg_next.pause_ticks    = cfg_data[9:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_bits     <= rcmm_pkg::FRAME_BITS_RST;
            cfg_reg.trailer_enable <= rcmm_pkg::TRAILER_EN_RST;
            cfg_reg.pause_ticks    <= rcmm_pkg::PAUSE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/rcmm_fsm.sv
// ----------------------------------------------------------------------------
// rcmm_fsm
// Frame sequencer: phase, shift word and counters, one step per beat.
// ----------------------------------------------------------------------------
module rcmm_fsm
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_valid,
    input  logic                req_type,
    input  logic [31:0]         code_word,
    input  rcmm_pkg::cfg_t      cfg,
    output rcmm_pkg::result_t   result
);

    rcmm_pkg::phase_t phase_reg, phase_next;
    logic [31:0]      shift_word_reg, shift_word_next;
    logic [5:0]       bits_sent_reg, bits_sent_next;
    logic [9:0]       wait_count_reg, wait_count_next;
    logic             carrier_reg, carrier_next;
    logic [6:0]       bits_plus;
    logic [9:0]       wait_plus;

    assign bits_plus = {1'b0, bits_sent_reg} + 7'd2;
    assign wait_plus = wait_count_reg + 10'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        shift_word_next = shift_word_reg;
        bits_sent_next  = bits_sent_reg;
        wait_count_next = wait_count_reg;
        carrier_next    = carrier_reg;
        result.duration = rcmm_pkg::DUR_NONE;
        result.busy_res = 1'b0;
        result.accepted = 1'b0;

        if (req_type == rcmm_pkg::REQ_START)
        begin
            if (phase_reg == rcmm_pkg::PH_IDLE && code_word != 32'd0)
            begin
                shift_word_next = code_word;
                phase_next      = rcmm_pkg::PH_HDR_A;
                result.accepted = 1'b1;
            end
            result.busy_res = (phase_next != rcmm_pkg::PH_IDLE);
        end
        else
        begin
            result.busy_res = 1'b1;
            case (phase_reg)
                rcmm_pkg::PH_HDR_A:
                begin
                    carrier_next    = 1'b1;
                    result.duration = rcmm_pkg::DUR_HDR_ON;
                    phase_next      = rcmm_pkg::PH_HDR_B;
                end
                rcmm_pkg::PH_HDR_B:
                begin
                    carrier_next    = 1'b0;
                    result.duration = rcmm_pkg::DUR_HDR_OFF;
                    phase_next      = rcmm_pkg::PH_BIT_A;
                end
                rcmm_pkg::PH_BIT_A:
                begin
                    carrier_next    = 1'b1;
                    result.duration = rcmm_pkg::DUR_PULSE;
                    phase_next      = rcmm_pkg::PH_BIT_B;
                end
                rcmm_pkg::PH_BIT_B:
                begin
                    carrier_next    = 1'b0;
                    result.duration = rcmm_pkg::pair_off_time(shift_word_reg[31:30]);
                    shift_word_next = {shift_word_reg[29:0], 2'b00};
                    bits_sent_next  = bits_plus[5:0];
                    phase_next      = (bits_plus >= {1'b0, cfg.frame_bits}) ?
                                      rcmm_pkg::PH_TRAIL : rcmm_pkg::PH_BIT_A;
                end
                rcmm_pkg::PH_TRAIL:
                begin
                    if (cfg.trailer_enable)
                    begin
                        carrier_next    = 1'b1;
                        result.duration = rcmm_pkg::DUR_PULSE;
                    end
                    else
                    begin
                        result.duration = rcmm_pkg::DUR_NO_TRAIL;
                    end
                    phase_next = rcmm_pkg::PH_WAIT;
                end
                rcmm_pkg::PH_WAIT:
                begin
                    carrier_next    = 1'b0;
                    result.duration = rcmm_pkg::DUR_PULSE;
                    wait_count_next = wait_plus;
                    if (wait_plus >= cfg.pause_ticks)
                    begin
                        bits_sent_next  = 6'd0;
                        wait_count_next = 10'd0;
                        phase_next      = rcmm_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    carrier_next    = 1'b0;
                    phase_next      = rcmm_pkg::PH_IDLE;
                    result.busy_res = 1'b0;
                end
            endcase
        end
        result.carrier_on = carrier_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rcmm_pkg::PH_IDLE;
            shift_word_reg <= 32'd0;
            bits_sent_reg  <= 6'd0;
            wait_count_reg <= 10'd0;
            carrier_reg    <= 1'b0;
        end
        else if (step_valid)
        begin
            phase_reg      <= phase_next;
            shift_word_reg <= shift_word_next;
            bits_sent_reg  <= bits_sent_next;
            wait_count_reg <= wait_count_next;
            carrier_reg    <= carrier_next;
        end
    end

    a_accept_starts_header : assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && result.accepted |=> phase_reg == rcmm_pkg::PH_HDR_A)
        else $error("accepted start did not enter the header");

    a_idle_tick_silent : assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && req_type == rcmm_pkg::REQ_TICK && phase_reg == rcmm_pkg::PH_IDLE
        |-> !result.carrier_on && result.duration == rcmm_pkg::DUR_NONE && !result.busy_res)
        else $error("idle tick produced an interval");

    a_bits_even : assert property (@(posedge clk) disable iff (!rst_n)
        !bits_sent_reg[0])
        else $error("odd bit count");

    a_wait_only_in_pause : assert property (@(posedge clk) disable iff (!rst_n)
        wait_count_reg != 10'd0 |-> phase_reg == rcmm_pkg::PH_WAIT)
        else $error("wait counter running outside the pause");

endmodule
